@@ src/crbm_pkg.sv @@
// Shared types and constants of the CSR row block mask generator.
package crbm_pkg;

	localparam int LANES_DEF  = 16;
	localparam int QDEPTH_DEF = 2;
	localparam int ROW_W      = 16;
	localparam int CNT_W      = 10;
	localparam int MASK_W     = 16;

	// One classified request as it travels from the front to the back
	typedef struct packed {
		logic             tile_end;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] cnt;
	} crbm_req_t;

	// Handshake between the request queue and the mark sequencer
	typedef struct packed {
		logic      valid;
		crbm_req_t data;
	} crbm_head_t;

endpackage

@@ src/crbm_front.sv @@
// Front stage: accepts requests, saturates the nonzero count and classifies tile ends.
module crbm_front import crbm_pkg::*; #(
	parameter int LANES = LANES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] row_index,
	input  logic [CNT_W-1:0] nonzero_count,
	input  logic             tile_end,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             push_valid,
	input  logic             push_ready,
	output crbm_req_t        push_data
);

	localparam int MAX_NNZ = 63 * LANES + 1;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int SAT     = (MAX_NNZ > CNT_MAX) ? CNT_MAX : MAX_NNZ;
	localparam logic [CNT_W-1:0] SAT_CNT = CNT_W'(SAT);

	logic      valid_s1;
	crbm_req_t req_s1;
	crbm_req_t req_c;

	// Classify: a tile end drops the row fields, a row has its count capped
	always_comb begin
		req_c.tile_end = tile_end;
		if (tile_end) begin
			req_c.row = '0;
			req_c.cnt = '0;
		end else begin
			req_c.row = row_index;
			req_c.cnt = (nonzero_count > SAT_CNT) ? SAT_CNT : nonzero_count;
		end
	end

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = req_s1;

	// Hold the classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_c;
		end
	end

endmodule

@@ src/crbm_queue.sv @@
// Short request queue that decouples the front stage from the mark sequencer.
module crbm_queue import crbm_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  crbm_req_t  push_data,
	output crbm_head_t head,
	input  logic       pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	crbm_req_t         entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign head.valid = (fill_q != '0);
	assign head.data  = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head.valid;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ src/crbm_back.sv @@
// Mark sequencer: walks each request across product blocks, one mark per cycle while mark_ready does not stall it.
module crbm_back import crbm_pkg::*; #(
	parameter int LANES = LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crbm_head_t        head,
	output logic              pop,
	output logic              mark_valid,
	input  logic              mark_ready,
	output logic [ROW_W-1:0]  mark_row,
	output logic [MASK_W-1:0] lane_mask,
	output logic              row_complete,
	output logic              fetch_block,
	output logic              tile_done,
	output logic              last_result
);

	localparam int POS_W = $clog2(LANES + 1);
	localparam int SUM_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int EXT_W = (LANES > MASK_W) ? LANES : MASK_W;
	localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(LANES);
	localparam logic [LANES-1:0] FULL = '1;

	logic              cur_valid_q;
	crbm_req_t         cur_q;
	logic [POS_W-1:0]  pos_q;

	logic              mark_valid_q;
	logic [ROW_W-1:0]  mark_row_q;
	logic [MASK_W-1:0] lane_mask_q;
	logic              row_complete_q;
	logic              fetch_block_q;
	logic              tile_done_q;
	logic              last_result_q;

	logic              fire;
	logic              fetch_c;
	logic [POS_W-1:0]  start_c;
	logic [SUM_W-1:0]  sum_c;
	logic              complete_c;
	logic [SUM_W-1:0]  stop_c;
	logic [LANES-1:0]  mask_c;
	logic [EXT_W-1:0]  mask_ext_c;
	logic [CNT_W-1:0]  rem_next_c;
	logic [POS_W-1:0]  pos_next_c;
	logic              last_c;

	// Work out the lanes of this block that the row covers
	always_comb begin
		fetch_c    = (pos_q >= POS_EMPTY);
		start_c    = fetch_c ? '0 : pos_q;
		sum_c      = SUM_W'(cur_q.cnt) + SUM_W'(start_c);
		complete_c = (sum_c <= SUM_W'(LANES));
		stop_c     = complete_c ? sum_c : SUM_W'(LANES);
		mask_c     = (FULL >> start_c) & ~(FULL >> stop_c);
		mask_ext_c = EXT_W'(mask_c);
		rem_next_c = cur_q.cnt - (CNT_W'(LANES) - CNT_W'(start_c));
		last_c     = cur_q.tile_end || complete_c;
		if (cur_q.tile_end) begin
			pos_next_c = POS_EMPTY;
		end else if (complete_c) begin
			pos_next_c = POS_W'(sum_c);
		end else begin
			pos_next_c = POS_EMPTY;
		end
	end

	assign fire = cur_valid_q && (!mark_valid_q || mark_ready);
	assign pop  = head.valid && (!cur_valid_q || (fire && last_c));

	// Load a request from the queue and step it through its blocks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			pos_q        <= POS_EMPTY;
			mark_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (fire && last_c) begin
				cur_valid_q <= 1'b0;
			end
			if (fire) begin
				pos_q <= pos_next_c;
			end
			if (fire) begin
				mark_valid_q <= 1'b1;
			end else if (mark_ready) begin
				mark_valid_q <= 1'b0;
			end
		end
	end

	// Hold the current request and the mark on offer
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.data;
		end else if (fire) begin
			cur_q.cnt <= rem_next_c;
		end
		if (fire) begin
			if (cur_q.tile_end) begin
				mark_row_q     <= '0;
				lane_mask_q    <= '0;
				row_complete_q <= 1'b0;
				fetch_block_q  <= 1'b0;
				tile_done_q    <= 1'b1;
			end else begin
				mark_row_q     <= cur_q.row;
				lane_mask_q    <= mask_ext_c[MASK_W-1:0];
				row_complete_q <= complete_c;
				fetch_block_q  <= fetch_c;
				tile_done_q    <= 1'b0;
			end
			last_result_q <= last_c;
		end
	end

	assign mark_valid   = mark_valid_q;
	assign mark_row     = mark_row_q;
	assign lane_mask    = lane_mask_q;
	assign row_complete = row_complete_q;
	assign fetch_block  = fetch_block_q;
	assign tile_done    = tile_done_q;
	assign last_result  = last_result_q;

endmodule

@@ src/csr_row_block_mask_generator.sv @@
// CSR row block mask generator: top level joining front stage, queue and mark sequencer.
//
// Each request is one CSR row (row_index, nonzero_count) or a tile end. The
// block emits one mark per product block of LANES lanes that the row touches,
// one mark per clock cycle from the sequencer unless mark_ready holds it: a
// row that starts at lane p with n nonzeros gives 1 + ceil((n - (LANES -
// p)) / LANES) marks (at least one, a row with no nonzeros gives one empty
// mark), a tile end one mark. The sequencer is the rate limit; it picks up
// the next request in the same cycle that its last mark enters the output
// register. A request passes the input register, the request queue and the
// current request register first. The mark output is registered; requests
// are still accepted while a mark waits, until queue and input register fill.
module csr_row_block_mask_generator import crbm_pkg::*; #(
	parameter int LANES  = LANES_DEF,
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [ROW_W-1:0]  row_index,
	input  logic [CNT_W-1:0]  nonzero_count,
	input  logic              tile_end,
	output logic              mark_valid,
	input  logic              mark_ready,
	output logic [ROW_W-1:0]  mark_row,
	output logic [MASK_W-1:0] lane_mask,
	output logic              row_complete,
	output logic              fetch_block,
	output logic              tile_done,
	output logic              last_result
);

	logic       push_valid;
	logic       push_ready;
	crbm_req_t  push_data;
	crbm_head_t head;
	logic       pop;

	// Accept and classify requests
	crbm_front #(
		.LANES(LANES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_index    (row_index),
		.nonzero_count(nonzero_count),
		.tile_end     (tile_end),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// Buffer classified requests
	crbm_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.head      (head),
		.pop       (pop)
	);

	// Emit marks
	crbm_back #(
		.LANES(LANES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.mark_valid  (mark_valid),
		.mark_ready  (mark_ready),
		.mark_row    (mark_row),
		.lane_mask   (lane_mask),
		.row_complete(row_complete),
		.fetch_block (fetch_block),
		.tile_done   (tile_done),
		.last_result (last_result)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the CSR row block mask generator, with its own mark predictor.
module tb_top;
	import crbm_pkg::*;

	localparam int NUM_LANES  = LANES_DEF;
	localparam int CNT_CAP    = 63 * NUM_LANES + 1;
	localparam int MAX_MARKS  = 64;
	localparam int RAND_REQS  = 300;
	localparam int TAIL_WAIT  = 20;
	localparam int CYCLE_CAP  = 300000;

	// One pending request; a drain entry makes the sender wait for every mark
	typedef struct {
		bit               drain;
		bit               tile_end;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] cnt;
	} row_req_t;

	// One expected mark
	typedef struct {
		logic [ROW_W-1:0]  row;
		logic [MASK_W-1:0] mask;
		logic              complete;
		logic              fetch;
		logic              tdone;
		logic              last;
	} mark_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	logic [ROW_W-1:0]  row_index;
	logic [CNT_W-1:0]  nonzero_count;
	logic              tile_end;
	logic              mark_valid;
	logic              mark_ready;
	logic [ROW_W-1:0]  mark_row;
	logic [MASK_W-1:0] lane_mask;
	logic              row_complete;
	logic              fetch_block;
	logic              tile_done;
	logic              last_result;

	row_req_t    pending[$];
	mark_t       marks_due[$];
	logic [4:0]  lane_pos;
	bit          req_taken;
	int          send_gap;
	int          stall_left;
	int          cycles;
	int          errors;
	int          reqs_sent;
	int          marks_seen;
	int          fetches_seen;
	int          tiles_seen;

	csr_row_block_mask_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.row_index     (row_index),
		.nonzero_count (nonzero_count),
		.tile_end      (tile_end),
		.mark_valid    (mark_valid),
		.mark_ready    (mark_ready),
		.mark_row      (mark_row),
		.lane_mask     (lane_mask),
		.row_complete  (row_complete),
		.fetch_block   (fetch_block),
		.tile_done     (tile_done),
		.last_result   (last_result)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Work out the marks that one accepted request causes and advance the lane position
	task automatic predict_marks(input logic te, input logic [ROW_W-1:0] row,
			input logic [CNT_W-1:0] cnt);
		int    left;
		int    pos;
		int    bound;
		int    top;
		int    old;
		int    n;
		bit    fetch;
		bit    complete;
		bit [31:0] hi;
		bit [31:0] lo;
		mark_t m;
		if (te) begin
			m = '{row: '0, mask: '0, complete: 1'b0, fetch: 1'b0, tdone: 1'b1, last: 1'b1};
			marks_due.push_back(m);
			lane_pos = 5'(NUM_LANES);
			return;
		end
		left = int'(cnt);
		if (left > CNT_CAP)
			left = CNT_CAP;
		pos = int'(lane_pos);
		n = 0;
		do begin
			fetch = pos > NUM_LANES - 1;
			if (fetch)
				pos = 0;
			bound = left - 1 + pos;
			complete = bound < NUM_LANES;
			top = complete ? bound : NUM_LANES - 1;
			hi = 32'hFFFF >> pos;
			lo = (top < 0) ? 32'h0 : ((32'hFFFF << (NUM_LANES - 1 - top)) & 32'hFFFF);
			m = '{row: row, mask: MASK_W'(hi & lo), complete: complete, fetch: fetch,
				tdone: 1'b0, last: 1'b0};
			marks_due.push_back(m);
			n++;
			old = left;
			left -= NUM_LANES - pos;
			pos += old;
		end while (left > 0 && n < MAX_MARKS);
		marks_due[marks_due.size() - 1].last = 1'b1;
		if (pos < 0)
			pos = 0;
		if (pos > NUM_LANES)
			pos = NUM_LANES;
		lane_pos = 5'(pos);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic add_req(input bit te, input int row, input int cnt);
		pending.push_back('{drain: 1'b0, tile_end: te, row: ROW_W'(row), cnt: CNT_W'(cnt)});
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 70)
			return $urandom_range(1, 20);
		if (r < 92)
			return $urandom_range(21, 120);
		if (r < 97)
			return $urandom_range(121, CNT_CAP);
		return $urandom_range(CNT_CAP, 1023);
	endfunction

	// Predict on request acceptance, check marks as they leave
	always @(posedge clk) begin : monitor
		mark_t want;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Timeout after %0d cycles, %0d marks still expected", cycles,
				marks_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && req_valid && req_ready) begin
			predict_marks(tile_end, row_index, nonzero_count);
			req_taken = 1'b1;
			reqs_sent++;
		end
		if (arst_n && mark_valid && mark_ready) begin
			if (marks_due.size() == 0) begin
				$error("unexpected mark: row 0x%0h mask 0x%0h tile_done %0b", mark_row,
					lane_mask, tile_done);
				errors++;
			end else begin
				want = marks_due.pop_front();
				check_field("mark_row", int'(want.row), int'(mark_row));
				check_field("lane_mask", int'(want.mask), int'(lane_mask));
				check_field("row_complete", int'(want.complete), int'(row_complete));
				check_field("fetch_block", int'(want.fetch), int'(fetch_block));
				check_field("tile_done", int'(want.tdone), int'(tile_done));
				check_field("last_result", int'(want.last), int'(last_result));
				marks_seen++;
				if (want.fetch)
					fetches_seen++;
				if (want.tdone)
					tiles_seen++;
			end
		end
	end

	// Request driver: hold until accepted, then advance, idle or wait at a drain point
	always @(negedge clk) begin : driver
		row_req_t nxt;
		bit relax;
		relax = (pending.size() < 30) || ((cycles % 400) < 80);
		if (!arst_n) begin
		end else if (req_valid && !req_taken) begin
		end else if (send_gap > 0) begin
			send_gap--;
			req_valid <= 1'b0;
		end else if (pending.size() > 0 && pending[0].drain) begin
			req_valid <= 1'b0;
			if (marks_due.size() == 0)
				void'(pending.pop_front());
		end else if (pending.size() > 0) begin
			nxt = pending.pop_front();
			row_index     <= nxt.row;
			nonzero_count <= nxt.cnt;
			tile_end      <= nxt.tile_end;
			req_valid     <= 1'b1;
			if (!relax && $urandom_range(0, 3) == 0)
				send_gap = $urandom_range(1, 3);
		end else begin
			req_valid <= 1'b0;
		end
		req_taken = 1'b0;
	end

	// Mark receiver: stall in short bursts, none near the end
	always @(negedge clk) begin : receiver
		bit relax;
		relax = (pending.size() < 30) || ((cycles % 400) >= 320);
		if (stall_left > 0) begin
			stall_left--;
			mark_ready <= 1'b0;
		end else if (!relax && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			mark_ready <= 1'b0;
		end else begin
			mark_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int made;
		int rows;
		int base;
		int k;
		bit drained;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		row_index     = '0;
		nonzero_count = '0;
		tile_end      = 1'b0;
		mark_ready    = 1'b0;
		lane_pos      = 5'(NUM_LANES);
		req_taken     = 1'b0;
		send_gap      = 0;
		stall_left    = 0;
		cycles        = 0;
		errors        = 0;
		reqs_sent     = 0;
		marks_seen    = 0;
		fetches_seen  = 0;
		tiles_seen    = 0;

		// Directed: empty rows on an exhausted and a part-used block, block edges,
		// saturated counts, extreme row indices and tile ends with junk fields
		add_req(1'b1, 0, 0);
		add_req(1'b0, 0, 0);
		add_req(1'b0, 16'hFFFF, 1);
		add_req(1'b0, 1, 0);
		add_req(1'b0, 2, 14);
		add_req(1'b0, 3, 0);
		add_req(1'b0, 4, 16);
		add_req(1'b0, 5, 17);
		add_req(1'b0, 6, 15);
		add_req(1'b1, 16'hFFFF, 10'h3FF);
		add_req(1'b1, 16'h5A5A, 10'h155);
		add_req(1'b0, 7, 1009);
		add_req(1'b0, 8, 3);
		add_req(1'b0, 9, 1010);
		add_req(1'b0, 16'hA5A5, 1023);
		add_req(1'b0, 10, 512);
		add_req(1'b0, 11, 33);
		add_req(1'b1, 0, 0);
		add_req(1'b0, 16'h8000, 31);
		add_req(1'b0, 12, 0);
		pending.push_back('{drain: 1'b1, tile_end: 1'b0, row: '0, cnt: '0});

		// Random: mostly tiles of ascending rows closed by a tile end, some noise
		made = 0;
		drained = 1'b0;
		while (made < RAND_REQS) begin
			if ($urandom_range(0, 99) < 85) begin
				rows = $urandom_range(1, 12);
				base = $urandom_range(0, 16'hFFF0);
				for (k = 0; k < rows; k++) begin
					add_req(1'b0, base, pick_count());
					base = (base + $urandom_range(0, 3)) & 16'hFFFF;
				end
				add_req(1'b1, $urandom, $urandom);
				made += rows + 1;
			end else begin
				add_req(1'($urandom_range(0, 1)), $urandom, $urandom);
				made++;
			end
			if (!drained && made > RAND_REQS / 2) begin
				pending.push_back('{drain: 1'b1, tile_end: 1'b0, row: '0, cnt: '0});
				drained = 1'b1;
			end
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Drain: all requests sent, all marks back, then a short quiet tail
		while (pending.size() != 0 || req_valid)
			@(posedge clk);
		while (marks_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Sent %0d requests and checked %0d marks", reqs_sent, marks_seen);
		$display("Marks with a block fetch: %0d, tile terminators: %0d", fetches_seen,
			tiles_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ csr_row_block_mask_generator.f @@
src/crbm_pkg.sv
src/crbm_front.sv
src/crbm_queue.sv
src/crbm_back.sv
src/csr_row_block_mask_generator.sv
tb/tb_top.sv
